>>> rtl/core/rlx_pkg.sv
// Shared constants, types and helpers for the subtract-with-borrow generator.
package rlx_pkg;

    localparam int WORD_BITS       = 24;
    localparam int RING_DEPTH      = 24;
    localparam int PTR_W           = $clog2(RING_DEPTH);
    localparam int LONG_LAG_START  = 23;
    localparam int SHORT_LAG_START = 9;
    localparam int BLOCK_OUTPUTS   = 24;
    localparam int PAD_BITS        = WORD_BITS / 2;
    localparam int SKIP_W          = 9;
    localparam int SKIP_RESET      = 199;
    localparam int CNT_LOW_W       = 30;
    localparam int CNT_HIGH_W      = 32;
    localparam int RESULT_W        = 2 * WORD_BITS;
    localparam int IN_DATA_W       = 32;
    localparam int OUT_DATA_W      = 112;
    localparam int CMD_QUEUE_DEPTH = 2;

    localparam logic [CNT_LOW_W-1:0] BILLION = 30'd1000000000;

    // Input op codes
    localparam logic [1:0] OP_GEN    = 2'd0;
    localparam logic [1:0] OP_SEED   = 2'd1;
    localparam logic [1:0] OP_BORROW = 2'd2;

    typedef enum logic [1:0] {
        CMD_GEN,
        CMD_SEED,
        CMD_BORROW
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [PTR_W-1:0]      index;
        logic [WORD_BITS-1:0]  value;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } eng_state_t;

    // Step a lag pointer down by one, wrapping below zero to the top of the ring.
    function automatic logic [PTR_W-1:0] ptr_down(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == '0)
        begin
            r = PTR_W'(RING_DEPTH - 1);
        end
        else
        begin
            r = p - PTR_W'(1);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/ranlux_luxury_random_generator.sv
// Top level of the 24-bit subtract-with-borrow luxury random generator.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------------------
//   s_*      | in        | s_tvalid/s_tready  | s_tdata: op, seed_index, seed_value
//   m_*      | out       | m_tvalid/m_tready  | m_tdata: random_value, count_low, count_high
//   cfg_*    | in        | cfg_valid/cfg_ready| cfg_data: skip_count
//
// A generate transfer passes through the engine's run and done states; every 24th one also
// runs skip_count discarded steps, one per cycle through the dual-read seed ring.
// Seed and borrow loads complete in the engine's idle state; unused ops are dropped at the front.
// Reset (rst_n, asynchronous) clears the ring valid bits, so the ring reads as zero.
// The command queue lets the front accept while the engine runs; the output
// register holds a result until taken without blocking further loads.
module ranlux_luxury_random_generator #(
    parameter int QUEUE_DEPTH = rlx_pkg::CMD_QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream: [1:0] op, [6:2] seed_index, [30:7] seed_value, [31] zero
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rlx_pkg::IN_DATA_W-1:0]   s_tdata,
    // Output stream: [47:0] random_value, [77:48] count_low, [109:78] count_high
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rlx_pkg::OUT_DATA_W-1:0]  m_tdata,
    // Configuration: skip_count
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rlx_pkg::SKIP_W-1:0]      cfg_data
);

    import rlx_pkg::*;

    logic [SKIP_W-1:0] skip_count_reg;
    logic              q_full;
    logic              q_push;
    cmd_t              q_push_cmd;
    logic              q_pop;
    cmd_t              q_head;
    logic              q_not_empty;

    // Config writes always complete; user must write only with block idle; not enforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_count_reg <= SKIP_W'(SKIP_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            skip_count_reg <= cfg_data;
        end
    end

    // Front: decode and drop no-op items
    rlx_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (q_push),
        .push_cmd (q_push_cmd)
    );

    rlx_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty)
    );

    // Back: ring, steps, counters, result register
    rlx_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .skip_count (skip_count_reg),
        .cmd_valid  (q_not_empty),
        .cmd        (q_head),
        .cmd_pop    (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

>>> rtl/core/rlx_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
module rlx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

>>> rtl/core/rlx_front.sv
// Front end: accept input transfers, decode the op and queue useful commands.
module rlx_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rlx_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          q_full,
    output logic                          push,
    output rlx_pkg::cmd_t                 push_cmd
);

    import rlx_pkg::*;

    logic [1:0]           op;
    logic [4:0]           seed_index;
    logic [WORD_BITS-1:0] seed_value;
    logic                 useful;

    assign op         = s_tdata[1:0];
    assign seed_index = s_tdata[6:2];
    assign seed_value = s_tdata[30:7];
    assign s_tready   = !q_full;

    always_comb
    begin
        push_cmd.index = seed_index[PTR_W-1:0];
        push_cmd.value = seed_value;
        push_cmd.kind  = CMD_GEN;
        useful         = 1'b0;
        unique case (op)
            OP_GEN:
            begin
                push_cmd.kind = CMD_GEN;
                useful        = 1'b1;
            end
            OP_SEED:
            begin
                // drop writes beyond the ring
                push_cmd.kind = CMD_SEED;
                useful        = (seed_index < 5'(RING_DEPTH));
            end
            OP_BORROW:
            begin
                push_cmd.kind = CMD_BORROW;
                useful        = 1'b1;
            end
            default:
            begin
                useful = 1'b0;
            end
        endcase
    end

    assign push = s_tvalid && s_tready && useful;

endmodule

>>> rtl/core/rlx_cmd_queue.sv
// Short command queue between the front end and the step engine.
module rlx_cmd_queue #(
    parameter int DEPTH = rlx_pkg::CMD_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rlx_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output rlx_pkg::cmd_t head,
    output logic          not_empty
);

    import rlx_pkg::*;

    localparam int QPTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    cmd_t              mem_reg [DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    function automatic logic [QPTR_W-1:0] qinc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + QPTR_W'(1);
        end
        return r;
    endfunction

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? qinc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? qinc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/rlx_engine.sv
// Step engine: seed ring, pipelined subtract-with-borrow steps, counters, output register.
module rlx_engine (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [rlx_pkg::SKIP_W-1:0]     skip_count,
    input  logic                           cmd_valid,
    input  rlx_pkg::cmd_t                  cmd,
    output logic                           cmd_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rlx_pkg::OUT_DATA_W-1:0] m_tdata
);

    import rlx_pkg::*;

    eng_state_t               state_reg, state_next;
    logic [PTR_W-1:0]         sp_reg, sp_next;
    logic [PTR_W-1:0]         lp_reg, lp_next;
    logic                     borrow_reg, borrow_next;
    logic [PTR_W-1:0]         phase_reg, phase_next;
    logic [CNT_LOW_W-1:0]     cnt_low_reg, cnt_low_next;
    logic [CNT_HIGH_W-1:0]    cnt_high_reg, cnt_high_next;
    logic [RING_DEPTH-1:0]    valid_reg, valid_next;
    logic [SKIP_W-1:0]        issue_left_reg, issue_left_next;
    logic                     rd_step_reg, rd_step_next;
    logic                     first_reg, first_next;
    logic                     pad_pend_reg, pad_pend_next;
    logic                     skip_pend_reg, skip_pend_next;
    logic [PTR_W-1:0]         wr_addr_reg, wr_addr_next;
    logic [WORD_BITS-1:0]     x_reg, x_next;
    logic [RESULT_W-1:0]      res_reg, res_next;
    logic                     vs_reg, vl_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]    out_data_reg, out_data_next;

    logic                     ram_we;
    logic [PTR_W-1:0]         ram_waddr;
    logic [WORD_BITS-1:0]     ram_wdata;
    logic [WORD_BITS-1:0]     rdata_s, rdata_l;
    logic [WORD_BITS-1:0]     a_word, b_word;
    logic [WORD_BITS:0]       sub_val, diff;
    logic [CNT_LOW_W-1:0]     low_inc, low_skip;
    logic                     run_done;

    rlx_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (sp_reg),
        .rdata_a (rdata_s),
        .raddr_b (lp_reg),
        .rdata_b (rdata_l)
    );

    // Entries never written read as zero.
    assign a_word  = vs_reg ? rdata_s : '0;
    assign b_word  = vl_reg ? rdata_l : '0;
    assign sub_val = {1'b0, b_word} + (WORD_BITS + 1)'(borrow_reg);
    assign diff    = {1'b0, a_word} - sub_val;

    assign low_inc  = cnt_low_reg + CNT_LOW_W'(1);
    assign low_skip = cnt_low_reg + CNT_LOW_W'(skip_count);

    assign run_done = (issue_left_reg == '0) && !rd_step_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && (cmd.kind == CMD_GEN))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (run_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        sp_next         = sp_reg;
        lp_next         = lp_reg;
        borrow_next     = borrow_reg;
        phase_next      = phase_reg;
        cnt_low_next    = cnt_low_reg;
        cnt_high_next   = cnt_high_reg;
        valid_next      = valid_reg;
        issue_left_next = issue_left_reg;
        rd_step_next    = 1'b0;
        first_next      = 1'b0;
        pad_pend_next   = 1'b0;
        skip_pend_next  = skip_pend_reg;
        wr_addr_next    = wr_addr_reg;
        x_next          = x_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        cmd_pop         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = wr_addr_reg;
        ram_wdata       = diff[WORD_BITS-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        CMD_SEED:
                        begin
                            ram_we                = 1'b1;
                            ram_waddr             = cmd.index;
                            ram_wdata             = cmd.value;
                            valid_next[cmd.index] = 1'b1;
                        end
                        CMD_BORROW:
                        begin
                            borrow_next = cmd.value[0];
                            lp_next     = PTR_W'(LONG_LAG_START);
                            sp_next     = PTR_W'(SHORT_LAG_START);
                            phase_next  = '0;
                        end
                        CMD_GEN:
                        begin
                            // the ring is being read at the current pointers now
                            rd_step_next = 1'b1;
                            first_next   = 1'b1;
                            wr_addr_next = lp_reg;
                            sp_next      = ptr_down(sp_reg);
                            lp_next      = ptr_down(lp_reg);
                            if (low_inc == BILLION)
                            begin
                                cnt_low_next  = '0;
                                cnt_high_next = cnt_high_reg + CNT_HIGH_W'(1);
                            end
                            else
                            begin
                                cnt_low_next = low_inc;
                            end
                            if (phase_reg == PTR_W'(BLOCK_OUTPUTS - 1))
                            begin
                                phase_next      = '0;
                                issue_left_next = skip_count;
                                skip_pend_next  = 1'b1;
                            end
                            else
                            begin
                                phase_next      = phase_reg + PTR_W'(1);
                                issue_left_next = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                // issue the next discarded step
                if (issue_left_reg != '0)
                begin
                    issue_left_next = issue_left_reg - SKIP_W'(1);
                    rd_step_next    = 1'b1;
                    wr_addr_next    = lp_reg;
                    sp_next         = ptr_down(sp_reg);
                    lp_next         = ptr_down(lp_reg);
                end
                // finish the step whose words arrive now
                if (rd_step_reg)
                begin
                    ram_we                  = 1'b1;
                    valid_next[wr_addr_reg] = 1'b1;
                    borrow_next             = diff[WORD_BITS];
                    if (first_reg)
                    begin
                        x_next        = diff[WORD_BITS-1:0];
                        pad_pend_next = 1'b1;
                    end
                end
                // the short port now holds the pad word
                if (pad_pend_reg)
                begin
                    if (x_reg[WORD_BITS-1:PAD_BITS] == '0)
                    begin
                        if ((x_reg == '0) && (a_word == '0))
                        begin
                            res_next = RESULT_W'(1);
                        end
                        else
                        begin
                            res_next = {x_reg, a_word};
                        end
                    end
                    else
                    begin
                        res_next = {x_reg, {WORD_BITS{1'b0}}};
                    end
                end
                if (skip_pend_reg)
                begin
                    skip_pend_next = 1'b0;
                    if (low_skip >= BILLION)
                    begin
                        cnt_low_next  = low_skip - BILLION;
                        cnt_high_next = cnt_high_reg + CNT_HIGH_W'(1);
                    end
                    else
                    begin
                        cnt_low_next = low_skip;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, cnt_high_reg, cnt_low_reg, res_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Payload registers
    always_ff @(posedge clk)
    begin
        wr_addr_reg  <= wr_addr_next;
        x_reg        <= x_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sp_reg         <= PTR_W'(SHORT_LAG_START);
            lp_reg         <= PTR_W'(LONG_LAG_START);
            borrow_reg     <= 1'b0;
            phase_reg      <= '0;
            cnt_low_reg    <= '0;
            cnt_high_reg   <= '0;
            valid_reg      <= '0;
            issue_left_reg <= '0;
            rd_step_reg    <= 1'b0;
            first_reg      <= 1'b0;
            pad_pend_reg   <= 1'b0;
            skip_pend_reg  <= 1'b0;
            vs_reg         <= 1'b0;
            vl_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sp_reg         <= sp_next;
            lp_reg         <= lp_next;
            borrow_reg     <= borrow_next;
            phase_reg      <= phase_next;
            cnt_low_reg    <= cnt_low_next;
            cnt_high_reg   <= cnt_high_next;
            valid_reg      <= valid_next;
            issue_left_reg <= issue_left_next;
            rd_step_reg    <= rd_step_next;
            first_reg      <= first_next;
            pad_pend_reg   <= pad_pend_next;
            skip_pend_reg  <= skip_pend_next;
            vs_reg         <= valid_reg[sp_reg];
            vl_reg         <= valid_reg[lp_reg];
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

>>> tb/tb.sv
// Self-checking stream testbench for the 24-bit subtract-with-borrow luxury generator.
`timescale 1ns / 100ps

module tb;
    import rlx_pkg::*;

    // Run guard: well above the slowest correct run (max skip, full stalls, long gaps)
    localparam int CYCLE_LIMIT   = 1000000;
    // Quiet time before a skip_count write: covers a full discard pass of up to 511 steps
    localparam int SETTLE_CYCLES = 600;
    // Length of the long receiver hold-off used to back the block up
    localparam int STALL_CYCLES  = 400;
    // The op code that the block must drop without any effect
    localparam logic [1:0] OP_NONE = 2'd3;

    // One generated number as it leaves the block, fields from the highest bit down
    typedef struct packed {
        logic [CNT_HIGH_W-1:0] high;
        logic [CNT_LOW_W-1:0]  low;
        logic [RESULT_W-1:0]   value;
    } draw_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // [1:0] op, [6:2] seed_index, [30:7] seed_value, [31] zero
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // [47:0] random_value, [77:48] count_low, [109:78] count_high, rest zero
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [SKIP_W-1:0]      cfg_data  = '0;

    // Generator model: lag ring, borrow, both taps, position in the 24-output block,
    // billion-wrapped step counters and the discard length
    logic [WORD_BITS-1:0]   seed_words [RING_DEPTH];
    logic                   carry;
    logic [PTR_W-1:0]       far_tap;
    logic [PTR_W-1:0]       near_tap;
    int unsigned            block_pos;
    logic [CNT_LOW_W-1:0]   steps_low;
    logic [CNT_HIGH_W-1:0]  steps_high;
    int unsigned            discard_len;

    // Numbers the block still owes us, oldest first
    draw_t                  pending_draws [$];
    draw_t                  got_draw;
    draw_t                  want_draw;

    int unsigned            failures    = 0;
    int unsigned            cycle_count = 0;
    int unsigned            stall_left  = 0;
    // Bumped by a test to start a hold-off; the receiver acknowledges it
    int unsigned            stall_req   = 0;
    int unsigned            stall_ack   = 0;
    int                     send_idle_pct;
    int                     recv_idle_pct;

    ranlux_luxury_random_generator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Step a tap one position down the ring, wrapping from the bottom to the top
    function automatic logic [PTR_W-1:0] tap_down(input logic [PTR_W-1:0] p);
        if (p == '0)
        begin
            return PTR_W'(RING_DEPTH - 1);
        end
        return p - PTR_W'(1);
    endfunction

    // Advance the billion-wrapped step counters by n
    function automatic void add_steps(input int unsigned n);
        logic [31:0] sum;
        sum = 32'(steps_low) + n;
        if (sum >= 32'(BILLION))
        begin
            sum        = sum - 32'(BILLION);
            steps_high = steps_high + CNT_HIGH_W'(1);
        end
        steps_low = sum[CNT_LOW_W-1:0];
    endfunction

    // One subtract-with-borrow step: near minus far minus carry, written back at far.
    // In 25-bit arithmetic a negative difference always lands with bit 24 set,
    // so that bit is the new borrow and the low 24 bits are already wrapped.
    function automatic logic [WORD_BITS-1:0] next_swb_word();
        logic [WORD_BITS:0] diff;
        diff = {1'b0, seed_words[near_tap]} - {1'b0, seed_words[far_tap]}
               - (WORD_BITS + 1)'(carry);
        carry = diff[WORD_BITS];
        seed_words[far_tap] = diff[WORD_BITS-1:0];
        far_tap  = tap_down(far_tap);
        near_tap = tap_down(near_tap);
        return diff[WORD_BITS-1:0];
    endfunction

    // Apply one accepted item to the model; a generate queues the number it yields
    function automatic void run_generator_item(input logic [1:0] op,
                                               input logic [PTR_W-1:0] idx,
                                               input logic [WORD_BITS-1:0] val);
        logic [WORD_BITS-1:0] x;
        draw_t                d;
        case (op)
            OP_SEED:
            begin
                // indexes past the ring are dropped
                if (idx < PTR_W'(RING_DEPTH))
                begin
                    seed_words[idx] = val;
                end
            end
            OP_BORROW:
            begin
                carry     = val[0];
                far_tap   = PTR_W'(LONG_LAG_START);
                near_tap  = PTR_W'(SHORT_LAG_START);
                block_pos = 0;
            end
            OP_GEN:
            begin
                x = next_swb_word();
                add_steps(1);
                d.value = {x, {WORD_BITS{1'b0}}};
                // small fractions borrow their low half from the word now at the near tap
                if (x < WORD_BITS'(1 << PAD_BITS))
                begin
                    d.value = d.value + RESULT_W'(seed_words[near_tap]);
                    if (d.value == '0)
                    begin
                        d.value = RESULT_W'(1);
                    end
                end
                block_pos++;
                // end of a 24-output block: burn the luxury steps
                if (block_pos >= BLOCK_OUTPUTS)
                begin
                    block_pos = 0;
                    add_steps(discard_len);
                    repeat (discard_len) void'(next_swb_word());
                end
                d.low  = steps_low;
                d.high = steps_high;
                pending_draws.push_back(d);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Offer one item and hold it until the block takes it. Valid stays high between
    // back-to-back items so it never gets two updates in one step.
    task automatic send_item(input logic [1:0] op, input logic [PTR_W-1:0] idx,
                             input logic [WORD_BITS-1:0] val);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, val, idx, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        run_generator_item(op, idx, val);
    endtask

    // Stop offering, wait for every owed number, then let any discard pass finish
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_draws.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write skip_count with the block idle
    task automatic test_skip_setting(input logic [SKIP_W-1:0] v);
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        discard_len = 32'(v);
        cfg_valid <= 1'b0;
    endtask

    // Hand-picked items: zero result, padding, borrow paths, extremes, dropped items
    task automatic test_directed();
        // empty ring: difference is zero and so is the pad word, so the value is 1
        send_item(OP_GEN, 5'd0, 24'h000000);
        send_item(OP_GEN, 5'd0, 24'h000000);
        // restart taps, then set up a tiny difference so the pad word shows
        send_item(OP_BORROW, 5'd0, 24'h000000);
        send_item(OP_SEED, 5'd9, 24'h000005);
        send_item(OP_SEED, 5'd23, 24'h000003);
        send_item(OP_SEED, 5'd8, 24'hFFFFFF);
        send_item(OP_GEN, 5'd0, 24'h000000);
        // out-of-ring seed index and the unused op must change nothing
        send_item(OP_SEED, 5'd31, 24'hFFFFFF);
        send_item(OP_NONE, 5'd31, 24'hFFFFFF);
        // borrow in plus full-scale subtrahend: wraps to exactly zero, padded
        send_item(OP_BORROW, 5'd31, 24'hFFFFFF);
        send_item(OP_SEED, 5'd9, 24'h000000);
        send_item(OP_SEED, 5'd23, 24'hFFFFFF);
        send_item(OP_GEN, 5'd0, 24'h000000);
        // all ones minus all ones minus borrow: the largest word
        send_item(OP_SEED, 5'd22, 24'hFFFFFF);
        send_item(OP_GEN, 5'd0, 24'h000000);
        send_item(OP_SEED, 5'd0, 24'h000000);
        send_item(OP_GEN, 5'd0, 24'h000000);
        send_item(OP_GEN, 5'd0, 24'h000000);
        send_item(OP_GEN, 5'd0, 24'h000000);
    endtask

    // Mostly generates so blocks of 24 wrap often, mixed with reseeds, restarts and unused ops
    task automatic test_random_traffic(input int n);
        int                   pick;
        logic [1:0]           op;
        logic [PTR_W-1:0]     idx;
        logic [WORD_BITS-1:0] val;
        repeat (n)
        begin
            pick = $urandom_range(99);
            val  = WORD_BITS'($urandom);
            idx  = PTR_W'($urandom);
            if (pick < 70)
            begin
                op = OP_GEN;
            end
            else if (pick < 88)
            begin
                op = OP_SEED;
                // keep most seed loads inside the ring
                if ($urandom_range(9) != 0)
                begin
                    idx = PTR_W'($urandom_range(RING_DEPTH - 1));
                end
            end
            else if (pick < 95)
            begin
                op = OP_BORROW;
            end
            else
            begin
                op = OP_NONE;
            end
            send_item(op, idx, val);
        end
    endtask

    // Hold the output side off for a long stretch while generates keep coming,
    // so the block fills up and pushes back on its input
    task automatic test_output_stall();
        stall_req++;
        repeat (60) send_item(OP_GEN, PTR_W'($urandom), WORD_BITS'($urandom));
    endtask

    // Output side: random ready, or forced low while a hold-off is counting down
    always @(posedge clk)
    begin
        if (stall_req != stall_ack)
        begin
            stall_ack  <= stall_req;
            stall_left <= STALL_CYCLES;
            m_tready   <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each output transfer with the oldest owed number
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_draw.value = m_tdata[RESULT_W-1:0];
            got_draw.low   = m_tdata[RESULT_W +: CNT_LOW_W];
            got_draw.high  = m_tdata[RESULT_W + CNT_LOW_W +: CNT_HIGH_W];
            if (pending_draws.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected transfer, actual %h", $time, m_tdata);
            end
            else
            begin
                want_draw = pending_draws.pop_front();
                if (got_draw.value !== want_draw.value)
                begin
                    failures++;
                    $display("%0t: random_value expected %h actual %h",
                             $time, want_draw.value, got_draw.value);
                end
                if (got_draw.low !== want_draw.low)
                begin
                    failures++;
                    $display("%0t: count_low expected %0d actual %0d",
                             $time, want_draw.low, got_draw.low);
                end
                if (got_draw.high !== want_draw.high)
                begin
                    failures++;
                    $display("%0t: count_high expected %0d actual %0d",
                             $time, want_draw.high, got_draw.high);
                end
            end
        end
    end

    // Hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        for (int k = 0; k < RING_DEPTH; k++)
        begin
            seed_words[k] = '0;
        end
        carry         = 1'b0;
        far_tap       = PTR_W'(LONG_LAG_START);
        near_tap      = PTR_W'(SHORT_LAG_START);
        block_pos     = 0;
        steps_low     = '0;
        steps_high    = '0;
        discard_len   = SKIP_RESET;
        send_idle_pct = 21;
        recv_idle_pct = 65;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender busy, receiver sparse; first pass runs on the reset skip_count
        test_directed();
        test_random_traffic(140);
        test_skip_setting(SKIP_W'(0));
        test_random_traffic(140);
        test_skip_setting(SKIP_W'(365));
        test_output_stall();
        test_random_traffic(100);

        // sender sparse, receiver busy; largest skip the register holds
        send_idle_pct = 65;
        recv_idle_pct = 21;
        test_skip_setting(SKIP_W'(511));
        test_random_traffic(140);
        test_skip_setting(SKIP_W'(1));
        test_random_traffic(140);

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_skip_setting(SKIP_W'($urandom_range(364, 2)));
        test_random_traffic(140);
        test_skip_setting(SKIP_W'(24));
        test_random_traffic(220);

        wait_until_drained();
        if (failures == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/rlx_pkg.sv
rtl/core/rlx_ram.sv
rtl/core/rlx_front.sv
rtl/core/rlx_cmd_queue.sv
rtl/core/rlx_engine.sv
rtl/core/ranlux_luxury_random_generator.sv
tb/tb.sv
